### rtl/slww_pkg.sv
// Shared types and constants of the serial LCD window writer.
`timescale 1ns / 1ps

package slww_pkg;

  // Field widths
  localparam int unsigned KIND_W   = 3;
  localparam int unsigned COORD_W  = 9;
  localparam int unsigned COLOR_W  = 16;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned WORD_W   = 16;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 9;
  localparam int unsigned SEQ_W    = 4;

  // Input item kinds
  localparam logic [KIND_W-1:0] KIND_START_FILL  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_START_IMAGE = 3'd1;
  localparam logic [KIND_W-1:0] KIND_PIXEL       = 3'd2;
  localparam logic [KIND_W-1:0] KIND_LINK_ERROR  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_ABORT       = 3'd4;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_ERROR   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BUSY    = 2'd2;
  localparam logic [STATUS_W-1:0] ST_TIMEOUT = 2'd3;

  // Panel commands
  localparam logic [BYTE_W-1:0] CMD_COLUMN_WINDOW = 8'h2A;
  localparam logic [BYTE_W-1:0] CMD_ROW_WINDOW    = 8'h2B;
  localparam logic [BYTE_W-1:0] CMD_MEMORY_WRITE  = 8'h2C;

  // Configuration registers
  localparam logic [CFG_IDX_W-1:0] CFG_DISPLAY_READY = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLUMN_OFFSET = 1'd1;
  localparam logic [COORD_W-1:0]   OFFSET_AT_RESET   = 9'd34;

  // Byte positions inside the window sequence
  localparam logic [SEQ_W-1:0] SEQ_COL_CMD  = 4'd0;
  localparam logic [SEQ_W-1:0] SEQ_XS_HI    = 4'd1;
  localparam logic [SEQ_W-1:0] SEQ_XS_LO    = 4'd2;
  localparam logic [SEQ_W-1:0] SEQ_XE_HI    = 4'd3;
  localparam logic [SEQ_W-1:0] SEQ_XE_LO    = 4'd4;
  localparam logic [SEQ_W-1:0] SEQ_ROW_CMD  = 4'd5;
  localparam logic [SEQ_W-1:0] SEQ_YS_HI    = 4'd6;
  localparam logic [SEQ_W-1:0] SEQ_YS_LO    = 4'd7;
  localparam logic [SEQ_W-1:0] SEQ_YE_HI    = 4'd8;
  localparam logic [SEQ_W-1:0] SEQ_YE_LO    = 4'd9;
  localparam logic [SEQ_W-1:0] SEQ_MEM_CMD  = 4'd10;
  localparam logic [SEQ_W-1:0] SEQ_PIX_LO   = 4'd1;

  // Job kinds handed from the front to the back
  typedef enum logic [1:0] {
    OP_SINGLE,
    OP_PIXEL,
    OP_START
  } op_e;

  // One queued job; the words carry window addresses or the pixel
  typedef struct packed {
    op_e                 op;
    logic [STATUS_W-1:0] status;
    logic                cs_release;
    logic                busy_res;
    logic [WORD_W-1:0]   w0;
    logic [WORD_W-1:0]   w1;
    logic [WORD_W-1:0]   w2;
    logic [WORD_W-1:0]   w3;
  } job_t;

  // One result item
  typedef struct packed {
    logic [BYTE_W-1:0]   spi_byte;
    logic                is_data;
    logic                byte_valid;
    logic                cs_release;
    logic                last;
    logic [STATUS_W-1:0] status;
    logic                busy_res;
  } res_t;

endpackage

### rtl/slww_item_if.sv
// Input item channel of the serial LCD window writer.
`timescale 1ns / 1ps

interface slww_item_if;
  logic                               valid;
  logic                               ready;
  logic [slww_pkg::KIND_W-1:0]        kind;
  logic [slww_pkg::COORD_W-1:0]       x_start;
  logic [slww_pkg::COORD_W-1:0]       y_start;
  logic [slww_pkg::COORD_W-1:0]       rect_width;
  logic [slww_pkg::COORD_W-1:0]       rect_height;
  logic [slww_pkg::COLOR_W-1:0]       color;

  modport source (output valid, kind, x_start, y_start, rect_width, rect_height, color,
                  input ready);
  modport sink (input valid, kind, x_start, y_start, rect_width, rect_height, color,
                output ready);
endinterface

### rtl/slww_result_if.sv
// Result item channel of the serial LCD window writer.
`timescale 1ns / 1ps

interface slww_result_if;
  logic                           valid;
  logic                           ready;
  logic [slww_pkg::BYTE_W-1:0]    spi_byte;
  logic                           is_data;
  logic                           byte_valid;
  logic                           cs_release;
  logic                           last;
  logic [slww_pkg::STATUS_W-1:0]  status;
  logic                           busy_res;

  modport source (output valid, spi_byte, is_data, byte_valid, cs_release, last, status,
                  busy_res, input ready);
  modport sink (input valid, spi_byte, is_data, byte_valid, cs_release, last, status,
                busy_res, output ready);
endinterface

### rtl/slww_front.sv
// Front end: accepts items, keeps transfer state and queues output jobs.
`timescale 1ns / 1ps

module slww_front #(
  parameter int unsigned PANEL_WIDTH  = 240,
  parameter int unsigned PANEL_HEIGHT = 320
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [slww_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [slww_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  slww_item_if.sink                          item_i,
  input  logic                               q_full_i,
  output logic                               push_o,
  output slww_pkg::job_t                     job_o
);

  localparam int unsigned SUM_W = slww_pkg::COORD_W + 1;
  localparam logic [SUM_W-1:0] PanelW = SUM_W'(PANEL_WIDTH);
  localparam logic [SUM_W-1:0] PanelH = SUM_W'(PANEL_HEIGHT);

  logic                               ready_q, ready_d;
  logic [slww_pkg::COORD_W-1:0]       offset_q, offset_d;
  logic                               busy_q, busy_d;
  logic                               fill_q, fill_d;
  logic [slww_pkg::COLOR_W-1:0]       fcolor_q, fcolor_d;
  logic [slww_pkg::COORD_W-1:0]       width_q, width_d;
  logic [slww_pkg::COORD_W-1:0]       height_q, height_d;
  logic [slww_pkg::COORD_W-1:0]       col_q, col_d;
  logic [slww_pkg::COORD_W-1:0]       row_q, row_d;
  logic [slww_pkg::STATUS_W-1:0]      lstat_q, lstat_d;

  logic                               accept;
  logic [SUM_W-1:0]                   x_end, y_end;
  logic [slww_pkg::WORD_W-1:0]        xs, xe, ye;
  logic [slww_pkg::COORD_W-1:0]       col_inc, row_inc;
  logic [slww_pkg::COLOR_W-1:0]       px;
  logic                               done;

  assign item_i.ready = !q_full_i;
  assign accept       = item_i.valid && !q_full_i;

  // Window bounds and addresses
  assign x_end = SUM_W'(item_i.x_start) + SUM_W'(item_i.rect_width);
  assign y_end = SUM_W'(item_i.y_start) + SUM_W'(item_i.rect_height);
  assign xs    = slww_pkg::WORD_W'(item_i.x_start) + slww_pkg::WORD_W'(offset_q);
  assign xe    = xs + slww_pkg::WORD_W'(item_i.rect_width) - 16'd1;
  assign ye    = slww_pkg::WORD_W'(item_i.y_start) + slww_pkg::WORD_W'(item_i.rect_height)
                 - 16'd1;

  // Pixel counters
  assign col_inc = col_q + 9'd1;
  assign row_inc = row_q + 9'd1;
  assign done    = (col_inc >= width_q) && (row_inc >= height_q);
  assign px      = fill_q ? fcolor_q : item_i.color;

  // Classify the item, update state and build the job
  always_comb begin
    ready_d  = ready_q;
    offset_d = offset_q;
    busy_d   = busy_q;
    fill_d   = fill_q;
    fcolor_d = fcolor_q;
    width_d  = width_q;
    height_d = height_q;
    col_d    = col_q;
    row_d    = row_q;
    lstat_d  = lstat_q;
    push_o   = 1'b0;
    job_o    = '0;
    job_o.op = slww_pkg::OP_SINGLE;

    if (cfg_we_i) begin
      case (cfg_idx_i)
        slww_pkg::CFG_DISPLAY_READY: ready_d  = cfg_data_i[0];
        slww_pkg::CFG_COLUMN_OFFSET: offset_d = cfg_data_i;
        default: ;
      endcase
    end

    if (accept) begin
      case (item_i.kind)
        slww_pkg::KIND_START_FILL, slww_pkg::KIND_START_IMAGE: begin
          push_o = 1'b1;
          if (!ready_q || busy_q) begin
            job_o.status   = slww_pkg::ST_BUSY;
            job_o.busy_res = busy_q;
          end else if (item_i.rect_width == '0 || item_i.rect_height == '0 ||
                       x_end > PanelW || y_end > PanelH) begin
            job_o.status = slww_pkg::ST_ERROR;
          end else begin
            job_o.op     = slww_pkg::OP_START;
            job_o.status = slww_pkg::ST_OK;
            job_o.w0     = xs;
            job_o.w1     = xe;
            job_o.w2     = slww_pkg::WORD_W'(item_i.y_start);
            job_o.w3     = ye;
            fill_d   = (item_i.kind == slww_pkg::KIND_START_FILL);
            fcolor_d = (item_i.kind == slww_pkg::KIND_START_FILL) ? item_i.color : '0;
            width_d  = item_i.rect_width;
            height_d = item_i.rect_height;
            col_d    = '0;
            row_d    = '0;
            lstat_d  = slww_pkg::ST_OK;
            busy_d   = 1'b1;
          end
        end
        slww_pkg::KIND_PIXEL: begin
          if (busy_q) begin
            push_o           = 1'b1;
            job_o.op         = slww_pkg::OP_PIXEL;
            job_o.status     = slww_pkg::ST_OK;
            job_o.w0         = px;
            job_o.cs_release = done;
            job_o.busy_res   = !done;
            if (col_inc >= width_q) begin
              col_d = '0;
              row_d = row_inc;
            end else begin
              col_d = col_inc;
            end
            if (done) begin
              busy_d  = 1'b0;
              fill_d  = 1'b0;
              lstat_d = slww_pkg::ST_OK;
            end
          end
        end
        slww_pkg::KIND_LINK_ERROR: begin
          if (busy_q) begin
            push_o           = 1'b1;
            job_o.status     = slww_pkg::ST_ERROR;
            job_o.cs_release = 1'b1;
            busy_d  = 1'b0;
            fill_d  = 1'b0;
            lstat_d = slww_pkg::ST_ERROR;
          end
        end
        slww_pkg::KIND_ABORT: begin
          push_o = 1'b1;
          if (busy_q) begin
            job_o.status     = slww_pkg::ST_TIMEOUT;
            job_o.cs_release = 1'b1;
            busy_d  = 1'b0;
            fill_d  = 1'b0;
            lstat_d = slww_pkg::ST_TIMEOUT;
          end else begin
            job_o.status = lstat_q;
          end
        end
        default: ;
      endcase
    end
  end

  // Hold configuration and transfer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ready_q  <= 1'b0;
      offset_q <= slww_pkg::OFFSET_AT_RESET;
      busy_q   <= 1'b0;
      fill_q   <= 1'b0;
      fcolor_q <= '0;
      width_q  <= '0;
      height_q <= '0;
      col_q    <= '0;
      row_q    <= '0;
      lstat_q  <= slww_pkg::ST_OK;
    end else begin
      ready_q  <= ready_d;
      offset_q <= offset_d;
      busy_q   <= busy_d;
      fill_q   <= fill_d;
      fcolor_q <= fcolor_d;
      width_q  <= width_d;
      height_q <= height_d;
      col_q    <= col_d;
      row_q    <= row_d;
      lstat_q  <= lstat_d;
    end
  end

  // A pixel job only leaves the front while a transfer runs
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_o && job_o.op == slww_pkg::OP_PIXEL) |-> busy_q)
    else $error("pixel job queued while idle");

  // A started transfer always leaves the front busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_o && job_o.op == slww_pkg::OP_START) |=> busy_q)
    else $error("start job without busy transfer");

endmodule

### rtl/slww_queue.sv
// Short job queue between the front and the back.
`timescale 1ns / 1ps

module slww_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  slww_pkg::job_t data_i,
  input  logic           pop_i,
  output logic           full_o,
  output logic           valid_o,
  output slww_pkg::job_t data_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LastPtr = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FullCnt = CNT_W'(DEPTH);

  slww_pkg::job_t    mem_q [DEPTH];
  logic [PTR_W-1:0]  wr_q, wr_d;
  logic [PTR_W-1:0]  rd_q, rd_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign full_o  = (cnt_q == FullCnt);
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Advance pointers with wrap
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) wr_d = (wr_q == LastPtr) ? '0 : wr_q + 1'b1;
    if (do_pop)  rd_d = (rd_q == LastPtr) ? '0 : rd_q + 1'b1;
    if (do_push && !do_pop) cnt_d = cnt_q + 1'b1;
    else if (do_pop && !do_push) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Store pushed jobs
  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= data_i;
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) !(push_i && full_o))
    else $error("push into full job queue");

  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= FullCnt)
    else $error("job queue count overflow");

endmodule

### rtl/slww_back.sv
// Back end: expands queued jobs into serial bytes, one result item a cycle while the receiver takes them.
`timescale 1ns / 1ps

module slww_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           q_valid_i,
  input  slww_pkg::job_t job_i,
  output logic           pop_o,
  slww_result_if.source  result_o
);

  logic [slww_pkg::SEQ_W-1:0] idx_q, idx_d;
  logic                       out_valid_q, out_valid_d;
  slww_pkg::res_t             res_q, res_d;
  slww_pkg::res_t             cur;
  logic                       load, is_end;

  assign load = q_valid_i && (!out_valid_q || result_o.ready);

  // Form the byte at the current position of the head job
  always_comb begin
    cur        = '0;
    cur.status = slww_pkg::ST_OK;
    is_end     = 1'b1;
    case (job_i.op)
      slww_pkg::OP_SINGLE: begin
        cur.cs_release = job_i.cs_release;
        cur.last       = 1'b1;
        cur.status     = job_i.status;
        cur.busy_res   = job_i.busy_res;
      end
      slww_pkg::OP_PIXEL: begin
        cur.is_data    = 1'b1;
        cur.byte_valid = 1'b1;
        if (idx_q == slww_pkg::SEQ_PIX_LO) begin
          cur.spi_byte   = job_i.w0[7:0];
          cur.cs_release = job_i.cs_release;
          cur.last       = 1'b1;
          cur.busy_res   = job_i.busy_res;
        end else begin
          cur.spi_byte = job_i.w0[15:8];
          cur.busy_res = 1'b1;
          is_end       = 1'b0;
        end
      end
      slww_pkg::OP_START: begin
        cur.byte_valid = 1'b1;
        cur.is_data    = 1'b1;
        is_end         = 1'b0;
        case (idx_q)
          slww_pkg::SEQ_COL_CMD: begin
            cur.spi_byte   = slww_pkg::CMD_COLUMN_WINDOW;
            cur.is_data    = 1'b0;
            cur.cs_release = 1'b1;
          end
          slww_pkg::SEQ_XS_HI: cur.spi_byte = job_i.w0[15:8];
          slww_pkg::SEQ_XS_LO: cur.spi_byte = job_i.w0[7:0];
          slww_pkg::SEQ_XE_HI: cur.spi_byte = job_i.w1[15:8];
          slww_pkg::SEQ_XE_LO: begin
            cur.spi_byte   = job_i.w1[7:0];
            cur.cs_release = 1'b1;
          end
          slww_pkg::SEQ_ROW_CMD: begin
            cur.spi_byte   = slww_pkg::CMD_ROW_WINDOW;
            cur.is_data    = 1'b0;
            cur.cs_release = 1'b1;
          end
          slww_pkg::SEQ_YS_HI: cur.spi_byte = job_i.w2[15:8];
          slww_pkg::SEQ_YS_LO: cur.spi_byte = job_i.w2[7:0];
          slww_pkg::SEQ_YE_HI: cur.spi_byte = job_i.w3[15:8];
          slww_pkg::SEQ_YE_LO: begin
            cur.spi_byte   = job_i.w3[7:0];
            cur.cs_release = 1'b1;
          end
          default: begin
            cur.spi_byte   = slww_pkg::CMD_MEMORY_WRITE;
            cur.is_data    = 1'b0;
            cur.cs_release = 1'b1;
            cur.last       = 1'b1;
            cur.busy_res   = 1'b1;
            is_end         = 1'b1;
          end
        endcase
      end
      default: ;
    endcase
  end

  // Load the output register and step through the job
  always_comb begin
    idx_d       = idx_q;
    res_d       = res_q;
    out_valid_d = out_valid_q;
    pop_o       = 1'b0;
    if (out_valid_q && result_o.ready) out_valid_d = 1'b0;
    if (load) begin
      res_d       = cur;
      out_valid_d = 1'b1;
      if (is_end) begin
        pop_o = 1'b1;
        idx_d = '0;
      end else begin
        idx_d = idx_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign result_o.valid      = out_valid_q;
  assign result_o.spi_byte   = res_q.spi_byte;
  assign result_o.is_data    = res_q.is_data;
  assign result_o.byte_valid = res_q.byte_valid;
  assign result_o.cs_release = res_q.cs_release;
  assign result_o.last       = res_q.last;
  assign result_o.status     = res_q.status;
  assign result_o.busy_res   = res_q.busy_res;

  // Mid-job position implies the job is still at the queue head
  assert property (@(posedge clk_i) disable iff (!rst_ni) (idx_q != '0) |-> q_valid_i)
    else $error("sequence position without a job");

  assert property (@(posedge clk_i) disable iff (!rst_ni) idx_q <= slww_pkg::SEQ_MEM_CMD)
    else $error("sequence position out of range");

endmodule

### rtl/spi_lcd_window_writer_unit.sv
// Serial LCD window writer: top level joining front, job queue and back.
//
// Items enter on item_i (valid/ready) and results leave on result_o
// (valid/ready), one result item per byte or status event.
// A start item that is accepted yields 11 results: column-window command,
// four address bytes, row-window command, four address bytes and the
// memory-write command. Rejected starts, aborts and mid-transfer link
// errors yield a single status result; a pixel slot mid-transfer yields
// two data bytes, high first. The back emits one result per cycle while
// the receiver takes them. An item's job passes the job queue, and its
// results the output register, before they are valid. The front takes one
// item per cycle while the job queue has room (QUEUE_DEPTH jobs); a
// stalled receiver holds the output register and backs up the queue, and
// item_i.ready drops only once the queue is full. Configuration is
// written through cfg_we_i/cfg_idx_i/cfg_data_i; the user must do so only
// while the block is idle, which the block itself does not enforce. Reset
// clears the transfer state, sets display_ready to 0 and column_offset to
// 34, and empties the queue and the output register.
`timescale 1ns / 1ps

module spi_lcd_window_writer_unit #(
  parameter int unsigned PANEL_WIDTH  = 240,
  parameter int unsigned PANEL_HEIGHT = 320,
  parameter int unsigned QUEUE_DEPTH  = 2
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [slww_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [slww_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  slww_item_if.sink                        item_i,
  slww_result_if.source                    result_o
);

  logic           push, pop, q_full, q_valid;
  slww_pkg::job_t push_job, head_job;

  slww_front #(
    .PANEL_WIDTH  (PANEL_WIDTH),
    .PANEL_HEIGHT (PANEL_HEIGHT)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .item_i     (item_i),
    .q_full_i   (q_full),
    .push_o     (push),
    .job_o      (push_job)
  );

  slww_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_job),
    .pop_i   (pop),
    .full_o  (q_full),
    .valid_o (q_valid),
    .data_o  (head_job)
  );

  slww_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .job_i     (head_job),
    .pop_o     (pop),
    .result_o  (result_o)
  );

endmodule

### sim/testbench.sv
// Testbench of the serial LCD window writer: predicts the serial result stream per item.
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned PANEL_W       = 240;
  localparam int unsigned PANEL_H       = 320;
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned CYCLE_LIMIT   = 200000;
  localparam int unsigned REPORT_MAX    = 10;

  // Kind code with no meaning to the block
  localparam logic [slww_pkg::KIND_W-1:0] KIND_RESERVED = 3'd5;

  typedef struct packed {
    logic [slww_pkg::KIND_W-1:0]  kind;
    logic [slww_pkg::COORD_W-1:0] x;
    logic [slww_pkg::COORD_W-1:0] y;
    logic [slww_pkg::COORD_W-1:0] w;
    logic [slww_pkg::COORD_W-1:0] h;
    logic [slww_pkg::COLOR_W-1:0] color;
  } lcd_item_t;

  typedef struct {
    logic                          panel_ready;
    logic [slww_pkg::COORD_W-1:0]  col_offset;
    logic                          active;
    logic                          fill;
    logic [slww_pkg::COLOR_W-1:0]  fill_rgb;
    logic [slww_pkg::COORD_W-1:0]  win_w;
    logic [slww_pkg::COORD_W-1:0]  win_h;
    logic [slww_pkg::COORD_W-1:0]  col_cnt;
    logic [slww_pkg::COORD_W-1:0]  row_cnt;
    logic [slww_pkg::STATUS_W-1:0] end_status;
  } window_state_t;

  logic                            clk_i      = 1'b0;
  logic                            rst_ni     = 1'b0;
  logic                            cfg_we_i   = 1'b0;
  logic [slww_pkg::CFG_IDX_W-1:0]  cfg_idx_i  = slww_pkg::CFG_DISPLAY_READY;
  logic [slww_pkg::CFG_DATA_W-1:0] cfg_data_i = '0;

  slww_item_if   item_ch ();
  slww_result_if result_ch ();

  spi_lcd_window_writer_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .item_i     (item_ch),
    .result_o   (result_ch)
  );

  lcd_item_t      items_to_send[$];
  slww_pkg::res_t serial_results_due[$];
  window_state_t  panel;
  lcd_item_t      on_wire;

  bit          send_gaps;
  bit          recv_stalls;
  int unsigned gap_left;
  int unsigned stall_left;
  int unsigned queued_count;
  int unsigned accepted_count;
  int unsigned checked_count;
  int unsigned fail_count;
  int unsigned windows_done;
  int unsigned windows_cut;
  int unsigned starts_turned_away;
  int unsigned cycle_count;

  always #5 clk_i = ~clk_i;

  function automatic slww_pkg::res_t serial_result(input logic [slww_pkg::BYTE_W-1:0] b,
                                                   input logic dc, input logic v,
                                                   input logic cs, input logic fin,
                                                   input logic [slww_pkg::STATUS_W-1:0] st,
                                                   input logic bz);
    slww_pkg::res_t r;
    r.spi_byte   = b;
    r.is_data    = dc;
    r.byte_valid = v;
    r.cs_release = cs;
    r.last       = fin;
    r.status     = st;
    r.busy_res   = bz;
    return r;
  endfunction

  function automatic string show(input slww_pkg::res_t r);
    return $sformatf("byte=%h dc=%b valid=%b cs=%b last=%b st=%0d busy=%b", r.spi_byte,
                     r.is_data, r.byte_valid, r.cs_release, r.last, r.status, r.busy_res);
  endfunction

  // Queue one window address, high byte first
  task automatic push_word(input logic [slww_pkg::WORD_W-1:0] word, input logic cs_after);
    serial_results_due.push_back(serial_result(word[15:8], 1'b1, 1'b1, 1'b0, 1'b0,
                                               slww_pkg::ST_OK, 1'b0));
    serial_results_due.push_back(serial_result(word[7:0], 1'b1, 1'b1, cs_after, 1'b0,
                                               slww_pkg::ST_OK, 1'b0));
  endtask

  // Close the open window with the given status
  task automatic end_window(input logic [slww_pkg::STATUS_W-1:0] st);
    panel.active     = 1'b0;
    panel.fill       = 1'b0;
    panel.end_status = st;
    windows_cut++;
    serial_results_due.push_back(serial_result('0, 1'b0, 1'b0, 1'b1, 1'b1, st, 1'b0));
  endtask

  // Work out the results one accepted item causes and advance the window state
  task automatic predict_serial_results(input lcd_item_t it);
    logic [slww_pkg::WORD_W-1:0] xs, xe, ye, px;
    int unsigned                 reach_x, reach_y;
    logic                        finished;
    reach_x = 32'(it.x) + 32'(it.w);
    reach_y = 32'(it.y) + 32'(it.h);
    case (it.kind)
      slww_pkg::KIND_START_FILL, slww_pkg::KIND_START_IMAGE: begin
        if (!panel.panel_ready || panel.active) begin
          starts_turned_away++;
          serial_results_due.push_back(serial_result('0, 1'b0, 1'b0, 1'b0, 1'b1,
                                                     slww_pkg::ST_BUSY, panel.active));
        end else if (it.w == 0 || it.h == 0 || reach_x > PANEL_W || reach_y > PANEL_H) begin
          starts_turned_away++;
          serial_results_due.push_back(serial_result('0, 1'b0, 1'b0, 1'b0, 1'b1,
                                                     slww_pkg::ST_ERROR, 1'b0));
        end else begin
          xs = slww_pkg::WORD_W'(it.x) + slww_pkg::WORD_W'(panel.col_offset);
          xe = xs + slww_pkg::WORD_W'(it.w) - slww_pkg::WORD_W'(1);
          ye = slww_pkg::WORD_W'(it.y) + slww_pkg::WORD_W'(it.h) - slww_pkg::WORD_W'(1);
          serial_results_due.push_back(serial_result(slww_pkg::CMD_COLUMN_WINDOW, 1'b0, 1'b1,
                                                     1'b1, 1'b0, slww_pkg::ST_OK, 1'b0));
          push_word(xs, 1'b0);
          push_word(xe, 1'b1);
          serial_results_due.push_back(serial_result(slww_pkg::CMD_ROW_WINDOW, 1'b0, 1'b1,
                                                     1'b1, 1'b0, slww_pkg::ST_OK, 1'b0));
          push_word(slww_pkg::WORD_W'(it.y), 1'b0);
          push_word(ye, 1'b1);
          serial_results_due.push_back(serial_result(slww_pkg::CMD_MEMORY_WRITE, 1'b0, 1'b1,
                                                     1'b1, 1'b1, slww_pkg::ST_OK, 1'b1));
          panel.fill       = (it.kind == slww_pkg::KIND_START_FILL);
          panel.fill_rgb   = (it.kind == slww_pkg::KIND_START_FILL) ? it.color : '0;
          panel.win_w      = it.w;
          panel.win_h      = it.h;
          panel.col_cnt    = '0;
          panel.row_cnt    = '0;
          panel.end_status = slww_pkg::ST_OK;
          panel.active     = 1'b1;
        end
      end
      slww_pkg::KIND_PIXEL: begin
        if (panel.active) begin
          px = panel.fill ? panel.fill_rgb : it.color;
          finished = 1'b0;
          panel.col_cnt = panel.col_cnt + 1'b1;
          if (panel.col_cnt >= panel.win_w) begin
            panel.col_cnt = '0;
            panel.row_cnt = panel.row_cnt + 1'b1;
            if (panel.row_cnt >= panel.win_h) finished = 1'b1;
          end
          serial_results_due.push_back(serial_result(px[15:8], 1'b1, 1'b1, 1'b0, 1'b0,
                                                     slww_pkg::ST_OK, 1'b1));
          if (finished) begin
            panel.active     = 1'b0;
            panel.fill       = 1'b0;
            panel.end_status = slww_pkg::ST_OK;
            windows_done++;
            serial_results_due.push_back(serial_result(px[7:0], 1'b1, 1'b1, 1'b1, 1'b1,
                                                       slww_pkg::ST_OK, 1'b0));
          end else begin
            serial_results_due.push_back(serial_result(px[7:0], 1'b1, 1'b1, 1'b0, 1'b1,
                                                       slww_pkg::ST_OK, 1'b1));
          end
        end
      end
      slww_pkg::KIND_LINK_ERROR: begin
        if (panel.active) end_window(slww_pkg::ST_ERROR);
      end
      slww_pkg::KIND_ABORT: begin
        if (panel.active) begin
          end_window(slww_pkg::ST_TIMEOUT);
        end else begin
          serial_results_due.push_back(serial_result('0, 1'b0, 1'b0, 1'b0, 1'b1,
                                                     panel.end_status, 1'b0));
        end
      end
      default: ;
    endcase
  endtask

  // Drive queued items, predicting each one as it is accepted
  always @(posedge clk_i) begin : item_driver
    lcd_item_t nxt;
    if (!rst_ni) begin
      item_ch.valid       <= 1'b0;
      item_ch.kind        <= slww_pkg::KIND_ABORT;
      item_ch.x_start     <= '0;
      item_ch.y_start     <= '0;
      item_ch.rect_width  <= '0;
      item_ch.rect_height <= '0;
      item_ch.color       <= '0;
      gap_left = 0;
    end else begin
      if (item_ch.valid && item_ch.ready) begin
        predict_serial_results(on_wire);
        accepted_count++;
      end
      if (!item_ch.valid || item_ch.ready) begin
        if (gap_left != 0 || items_to_send.size() == 0) begin
          item_ch.valid <= 1'b0;
          if (gap_left != 0) gap_left--;
        end else begin
          nxt = items_to_send.pop_front();
          on_wire = nxt;
          item_ch.valid       <= 1'b1;
          item_ch.kind        <= nxt.kind;
          item_ch.x_start     <= nxt.x;
          item_ch.y_start     <= nxt.y;
          item_ch.rect_width  <= nxt.w;
          item_ch.rect_height <= nxt.h;
          item_ch.color       <= nxt.color;
          gap_left = send_gaps ? $urandom_range(0, 4) : 0;
        end
      end
    end
  end

  // Take results with random stalls and compare against the oldest prediction
  always @(posedge clk_i) begin : result_monitor
    slww_pkg::res_t got, want;
    if (!rst_ni) begin
      result_ch.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (result_ch.valid && result_ch.ready) begin
        got.spi_byte   = result_ch.spi_byte;
        got.is_data    = result_ch.is_data;
        got.byte_valid = result_ch.byte_valid;
        got.cs_release = result_ch.cs_release;
        got.last       = result_ch.last;
        got.status     = result_ch.status;
        got.busy_res   = result_ch.busy_res;
        if (serial_results_due.size() == 0) begin
          fail_count++;
          if (fail_count <= REPORT_MAX) $display("unexpected result: %s", show(got));
        end else begin
          want = serial_results_due.pop_front();
          if (got !== want) begin
            fail_count++;
            if (fail_count <= REPORT_MAX)
              $display("result %0d mismatch: expected %s, got %s", checked_count, show(want),
                       show(got));
          end
          checked_count++;
        end
        stall_left = recv_stalls ? $urandom_range(0, 4) : 0;
      end
      if (stall_left != 0) begin
        result_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        result_ch.ready <= 1'b1;
      end
    end
  end

  // Bound the run
  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("FAILURE");
    $finish;
  end

  task automatic push_item(input logic [slww_pkg::KIND_W-1:0] k, input int unsigned x,
                           input int unsigned y, input int unsigned w,
                           input int unsigned h, input int unsigned c);
    lcd_item_t it;
    it.kind  = k;
    it.x     = slww_pkg::COORD_W'(x);
    it.y     = slww_pkg::COORD_W'(y);
    it.w     = slww_pkg::COORD_W'(w);
    it.h     = slww_pkg::COORD_W'(h);
    it.color = slww_pkg::COLOR_W'(c);
    items_to_send.push_back(it);
    queued_count++;
  endtask

  // Wait until every item is taken and every result has come, then let the block go quiet
  task automatic settle();
    @(negedge clk_i);
    while (items_to_send.size() != 0 || item_ch.valid || serial_results_due.size() != 0)
      @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_register(input logic [slww_pkg::CFG_IDX_W-1:0] idx,
                                input logic [slww_pkg::CFG_DATA_W-1:0] value);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    if (idx == slww_pkg::CFG_DISPLAY_READY) panel.panel_ready = value[0];
    else panel.col_offset = value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // One well-formed window: start, then its pixels, now and then cut short or poked
  task automatic queue_window();
    int unsigned w, h, x, y;
    int unsigned area, cut_at;
    w = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 12) : $urandom_range(1, 4);
    h = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 8) : $urandom_range(1, 4);
    x = ($urandom_range(0, 5) == 0) ? PANEL_W - w : $urandom_range(0, PANEL_W - w);
    y = ($urandom_range(0, 5) == 0) ? PANEL_H - h : $urandom_range(0, PANEL_H - h);
    push_item($urandom_range(0, 1) ? slww_pkg::KIND_START_FILL : slww_pkg::KIND_START_IMAGE,
              x, y, w, h, $urandom);
    area = w * h;
    cut_at = ($urandom_range(0, 7) == 0) ? $urandom_range(0, area - 1) : area;
    for (int unsigned k = 0; k < area; k++) begin
      if (k == cut_at) begin
        push_item($urandom_range(0, 1) ? slww_pkg::KIND_LINK_ERROR : slww_pkg::KIND_ABORT,
                  $urandom, $urandom, $urandom, $urandom, $urandom);
        break;
      end
      if ($urandom_range(0, 24) == 0)
        push_item(slww_pkg::KIND_START_IMAGE, $urandom_range(0, 10), $urandom_range(0, 10),
                  1, 1, $urandom);
      push_item(slww_pkg::KIND_PIXEL, $urandom, $urandom, $urandom, $urandom, $urandom);
    end
  endtask

  // Reconfigure while idle, then fill the item queue up to the given count
  task automatic run_phase(input logic ready, input logic [slww_pkg::CFG_DATA_W-1:0] offset,
                           input bit gaps, input bit stalls, input int unsigned until_count);
    settle();
    write_register(slww_pkg::CFG_DISPLAY_READY, {{(slww_pkg::CFG_DATA_W-1){1'b0}}, ready});
    write_register(slww_pkg::CFG_COLUMN_OFFSET, offset);
    send_gaps   = gaps;
    recv_stalls = stalls;
    while (queued_count < until_count) begin
      if ($urandom_range(0, 6) == 0) begin
        push_item(slww_pkg::KIND_W'($urandom_range(0, 7)), $urandom, $urandom, $urandom,
                  $urandom, $urandom);
        if ($urandom_range(0, 1))
          push_item(slww_pkg::KIND_ABORT, $urandom, $urandom, $urandom, $urandom, $urandom);
      end else begin
        queue_window();
      end
    end
  endtask

  initial begin : stimulus
    panel.panel_ready   = 1'b0;
    panel.col_offset    = slww_pkg::OFFSET_AT_RESET;
    panel.active        = 1'b0;
    panel.fill          = 1'b0;
    panel.fill_rgb      = '0;
    panel.win_w         = '0;
    panel.win_h         = '0;
    panel.col_cnt       = '0;
    panel.row_cnt       = '0;
    panel.end_status    = slww_pkg::ST_OK;
    send_gaps   = 1'b1;
    recv_stalls = 1'b1;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Panel not ready: starts answered busy, idle kinds
    push_item(slww_pkg::KIND_START_FILL, 0, 0, 1, 1, 'h1234);
    push_item(slww_pkg::KIND_ABORT, 0, 0, 0, 0, 0);
    push_item(slww_pkg::KIND_PIXEL, 0, 0, 0, 0, 'hFFFF);
    push_item(slww_pkg::KIND_LINK_ERROR, 0, 0, 0, 0, 0);
    settle();
    write_register(slww_pkg::CFG_DISPLAY_READY, slww_pkg::CFG_DATA_W'(1));

    // Smallest window, then zero sizes and windows off the panel
    push_item(slww_pkg::KIND_START_FILL, 0, 0, 1, 1, 'hFFFF);
    push_item(slww_pkg::KIND_PIXEL, 0, 0, 0, 0, 0);
    push_item(slww_pkg::KIND_START_IMAGE, 10, 10, 0, 5, 0);
    push_item(slww_pkg::KIND_START_FILL, 10, 10, 5, 0, 0);
    push_item(slww_pkg::KIND_START_IMAGE, 200, 0, 41, 1, 0);
    push_item(slww_pkg::KIND_START_FILL, 0, 300, 1, 21, 0);
    push_item(slww_pkg::KIND_START_IMAGE, 511, 511, 511, 511, 'hFFFF);
    // Bottom-right pixel; a start while busy
    push_item(slww_pkg::KIND_START_FILL, 239, 319, 1, 1, 0);
    push_item(slww_pkg::KIND_START_IMAGE, 0, 0, 1, 1, 0);
    push_item(slww_pkg::KIND_PIXEL, 511, 511, 511, 511, 'hFFFF);
    // Image window over two rows
    push_item(slww_pkg::KIND_START_IMAGE, 238, 318, 2, 2, 'hFFFF);
    push_item(slww_pkg::KIND_PIXEL, 0, 0, 0, 0, 0);
    push_item(slww_pkg::KIND_PIXEL, 511, 511, 511, 511, 'hFFFF);
    push_item(slww_pkg::KIND_PIXEL, 0, 0, 0, 0, 'hA5A5);
    push_item(slww_pkg::KIND_PIXEL, 0, 0, 0, 0, 'h5A5A);
    // Link error mid-window, then abort while idle reports it
    push_item(slww_pkg::KIND_START_FILL, 5, 5, 3, 3, 'hF800);
    push_item(slww_pkg::KIND_PIXEL, 0, 0, 0, 0, 0);
    push_item(slww_pkg::KIND_LINK_ERROR, 0, 0, 0, 0, 0);
    push_item(slww_pkg::KIND_ABORT, 0, 0, 0, 0, 0);
    // Full panel cut by abort, then abort reports the timeout
    push_item(slww_pkg::KIND_START_IMAGE, 0, 0, PANEL_W, PANEL_H, 0);
    push_item(slww_pkg::KIND_ABORT, 0, 0, 0, 0, 0);
    push_item(slww_pkg::KIND_ABORT, 0, 0, 0, 0, 0);
    push_item(slww_pkg::KIND_LINK_ERROR, 0, 0, 0, 0, 0);
    push_item(KIND_RESERVED, 511, 511, 511, 511, 'hFFFF);

    // Random windows under several settings, draining between them
    run_phase(1'b1, '0, 1'b1, 1'b1, 130);
    run_phase(1'b1, '1, 1'b0, 1'b0, 220);
    run_phase(1'b0, slww_pkg::CFG_DATA_W'($urandom), 1'b1, 1'b0, 250);
    run_phase(1'b1, slww_pkg::CFG_DATA_W'($urandom), 1'b0, 1'b1, 340);
    run_phase(1'b1, slww_pkg::OFFSET_AT_RESET, 1'b1, 1'b1, 430);
    settle();
    fail_count += serial_results_due.size();

    $display("Sent %0d items: %0d windows finished, %0d cut short, %0d starts turned away.",
             accepted_count, windows_done, windows_cut, starts_turned_away);
    $display("Checked %0d result items against the predicted serial stream.", checked_count);
    if (fail_count == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
